[design/srdw_pkg.sv]
// ---------------------------------------------------------------------------
// srdw_pkg
// Shared types and constants for the shadow register deferred writer: field
// layout of the stream words, command and register codes, and the control
// and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package srdw_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int LINE_W = 8;

  // Input word layout, lowest bit first.
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_IDX_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_DATA_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_LINE_LSB  = IN_DATA_LSB + VAL_W;
  localparam int IN_FBLK_BIT  = IN_LINE_LSB + LINE_W;
  localparam int IN_BITS      = IN_FBLK_BIT + 1;
  localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OUT_IDX_LSB   = 0;
  localparam int OUT_VAL_LSB   = OUT_IDX_LSB + IDX_W;
  localparam int OUT_MERGE_BIT = OUT_VAL_LSB + VAL_W;
  localparam int OUT_HW_BIT    = OUT_MERGE_BIT + 1;
  localparam int M_TDATA_W     = (((OUT_HW_BIT + 1) + 7) / 8) * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MASK  = 2'd2;
  localparam logic [LINE_W-1:0] BLANK_FIRST_RST = 8'd161;
  localparam logic [LINE_W-1:0] BLANK_LAST_RST  = 8'd225;

  // Which source feeds the output register.
  typedef enum logic [1:0] {
    SRC_WRITE = 2'd0,
    SRC_READ  = 2'd1,
    SRC_FLUSH = 2'd2
  } out_src_t;

  typedef struct packed {
    logic     cap_in;     // capture the accepted request
    logic     sh_rd_in;   // shadow read at the incoming index
    logic     sh_rd_q;    // shadow read at the queue entry just read
    logic     shadow_wr;  // commit the read-modify-write result
    logic     enqueue;    // queue the index unless already pending
    logic     out_load;   // load the output register
    out_src_t out_src;
    logic     fl_start;   // read queue entry zero
    logic     fl_next;    // advance to the next queue entry
    logic     fl_done;    // empty the queue
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] new_cmd;
    logic             new_in_range;
    logic             blank;
    logic             count_zero;
    logic             flush_last;
    logic             out_free;
  } dp_status_t;

endpackage

[design/srdw_ram.sv]
// ---------------------------------------------------------------------------
// srdw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that only updates when a read is issued.
// ---------------------------------------------------------------------------
module srdw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/srdw_dp.sv]
// ---------------------------------------------------------------------------
// srdw_dp
// Datapath: configuration registers, shadow RAM with per-entry valid bits,
// pending queue RAM with fill count and pending marks, and the output
// register.
// ---------------------------------------------------------------------------
module srdw_dp
  import srdw_pkg::*;
#(
  parameter int NUM_REGS         = 48,
  parameter int STATUS_INDEX     = 2,
  parameter int LINE_COUNT_INDEX = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           st,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  localparam int AW = $clog2(NUM_REGS);
  localparam int CW = $clog2(NUM_REGS + 1);
  localparam logic [IDX_W-1:0] STATUS_IDX = IDX_W'(STATUS_INDEX);
  localparam logic [IDX_W-1:0] LINE_IDX   = IDX_W'(LINE_COUNT_INDEX);
  localparam logic [IDX_W:0]   NUM_REGS_X = (IDX_W + 1)'(NUM_REGS);

  // Fields of the incoming request.
  logic [CMD_W-1:0]  new_cmd;
  logic [IDX_W-1:0]  new_idx;
  logic [VAL_W-1:0]  new_data;
  logic [LINE_W-1:0] new_line;
  logic              new_fblank;

  assign new_cmd    = s_tdata[IN_CMD_LSB +: CMD_W];
  assign new_idx    = s_tdata[IN_IDX_LSB +: IDX_W];
  assign new_data   = s_tdata[IN_DATA_LSB +: VAL_W];
  assign new_line   = s_tdata[IN_LINE_LSB +: LINE_W];
  assign new_fblank = s_tdata[IN_FBLK_BIT];

  // Configuration. The merge mask is applied by the hardware side only.
  logic [LINE_W-1:0] blank_first;
  logic [LINE_W-1:0] blank_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_first <= BLANK_FIRST_RST;
      blank_last  <= BLANK_LAST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_BLANK_FIRST: blank_first <= cfg_data[LINE_W-1:0];
        CFG_BLANK_LAST:  blank_last  <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] data_q;
  logic             blank_q;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_q   <= new_cmd;
      idx_q   <= new_idx;
      data_q  <= new_data;
      blank_q <= ((new_line >= blank_first) && (new_line <= blank_last)) || new_fblank;
    end
  end

  // Shadow store.
  logic [NUM_REGS-1:0] shadow_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_range;
  logic [VAL_W-1:0]    sh_rdata;
  logic [IDX_W-1:0]    q_rdata;
  logic [VAL_W-1:0]    old_val;
  logic [VAL_W-1:0]    new_val;
  logic                sh_rd_en;
  logic [AW-1:0]       sh_rd_addr;

  assign sh_rd_en   = cmd.sh_rd_in || cmd.sh_rd_q;
  assign sh_rd_addr = cmd.sh_rd_q ? q_rdata[AW-1:0] : new_idx[AW-1:0];

  srdw_ram #(.WIDTH(VAL_W), .DEPTH(NUM_REGS)) u_shadow (
    .clk     (clk),
    .wr_en   (cmd.shadow_wr),
    .wr_addr (idx_q[AW-1:0]),
    .wr_data (new_val),
    .rd_en   (sh_rd_en),
    .rd_addr (sh_rd_addr),
    .rd_data (sh_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.sh_rd_q) begin
      rd_idx   <= q_rdata;
      rd_range <= 1'b1;
    end else if (cmd.sh_rd_in) begin
      rd_idx   <= new_idx;
      rd_range <= {1'b0, new_idx} < NUM_REGS_X;
    end
  end

  // Entries never written read as zero, as do indexes past the file.
  assign old_val = (rd_range && shadow_vld[rd_idx[AW-1:0]]) ? sh_rdata : '0;

  always_comb begin
    case (cmd_q)
      CMD_SET:   new_val = old_val | data_q;
      CMD_CLEAR: new_val = old_val & ~data_q;
      default:   new_val = data_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_vld <= '0;
    end else if (cmd.shadow_wr) begin
      shadow_vld[idx_q[AW-1:0]] <= 1'b1;
    end
  end

  // Pending queue.
  logic [CW-1:0]       count;
  logic [AW-1:0]       ptr;
  logic [NUM_REGS-1:0] marks;
  logic                do_enq;
  logic                q_rd_en;
  logic [AW-1:0]       q_rd_addr;

  assign do_enq    = cmd.enqueue && !marks[idx_q[AW-1:0]];
  assign q_rd_en   = cmd.fl_start || cmd.fl_next;
  assign q_rd_addr = cmd.fl_start ? '0 : AW'(ptr + 1'b1);

  srdw_ram #(.WIDTH(IDX_W), .DEPTH(NUM_REGS)) u_queue (
    .clk     (clk),
    .wr_en   (do_enq),
    .wr_addr (count[AW-1:0]),
    .wr_data (idx_q),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      marks <= '0;
    end else if (cmd.fl_done) begin
      count <= '0;
      marks <= '0;
    end else if (do_enq) begin
      count <= count + 1'b1;
      marks[idx_q[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      ptr <= q_rd_addr;
    end
  end

  // Output register.
  logic [IDX_W-1:0] o_idx;
  logic [VAL_W-1:0] o_val;
  logic             o_merge;
  logic             o_hw;
  logic             o_kind;
  logic             o_last;
  logic             flush_last;

  assign flush_last = (CW'(ptr) + CW'(1)) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        SRC_READ: begin
          o_kind  <= 1'b1;
          o_idx   <= idx_q;
          o_val   <= old_val;
          o_merge <= 1'b0;
          o_hw    <= (idx_q == STATUS_IDX) || (idx_q == LINE_IDX);
          o_last  <= 1'b1;
        end
        SRC_FLUSH: begin
          o_kind  <= 1'b0;
          o_idx   <= rd_idx;
          o_val   <= old_val;
          o_merge <= rd_idx == STATUS_IDX;
          o_hw    <= 1'b0;
          o_last  <= flush_last;
        end
        default: begin
          o_kind  <= 1'b0;
          o_idx   <= idx_q;
          o_val   <= new_val;
          o_merge <= idx_q == STATUS_IDX;
          o_hw    <= 1'b0;
          o_last  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_IDX_LSB +: IDX_W] = o_idx;
    m_tdata[OUT_VAL_LSB +: VAL_W] = o_val;
    m_tdata[OUT_MERGE_BIT]        = o_merge;
    m_tdata[OUT_HW_BIT]           = o_hw;
  end

  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // Status to the controller.
  assign st.new_cmd      = new_cmd;
  assign st.new_in_range = {1'b0, new_idx} < NUM_REGS_X;
  assign st.blank        = blank_q;
  assign st.count_zero   = count == '0;
  assign st.flush_last   = flush_last;
  assign st.out_free     = !m_tvalid || m_tready;

endmodule

[design/srdw_ctrl.sv]
// ---------------------------------------------------------------------------
// srdw_ctrl
// Controller: sequences the shadow read-modify-write, reads, and the flush
// walk over the pending queue.
// ---------------------------------------------------------------------------
module srdw_ctrl
  import srdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RMW   = 5'b00010,
    S_READ  = 5'b00100,
    S_FLQ   = 5'b01000,
    S_FLS   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.out_src = SRC_WRITE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          unique case (st.new_cmd) inside
            CMD_WRITE, CMD_SET, CMD_CLEAR: begin
              if (st.new_in_range) begin
                cmd.sh_rd_in = 1'b1;
                state_next   = S_RMW;
              end
            end
            CMD_READ: begin
              cmd.sh_rd_in = 1'b1;
              state_next   = S_READ;
            end
            CMD_FLUSH: begin
              if (!st.count_zero) begin
                cmd.fl_start = 1'b1;
                state_next   = S_FLQ;
              end
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        if (!st.blank) begin
          cmd.shadow_wr = 1'b1;
          cmd.enqueue   = 1'b1;
          state_next    = S_IDLE;
        end else if (st.out_free) begin
          cmd.shadow_wr = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_src   = SRC_WRITE;
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_READ;
          state_next   = S_IDLE;
        end
      end
      S_FLQ: begin
        cmd.sh_rd_q = 1'b1;
        state_next  = S_FLS;
      end
      S_FLS: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_FLUSH;
          if (st.flush_last) begin
            cmd.fl_done = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.fl_next = 1'b1;
            state_next  = S_FLQ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/shadow_register_deferred_writer.sv]
// ---------------------------------------------------------------------------
// shadow_register_deferred_writer
// Shadow copy of the display registers with a deduplicated queue of
// deferred hardware writes, flushed on request.
// ---------------------------------------------------------------------------
// Requests arrive on the s_t* channel: write, set bits, clear bits, read or
// flush. Results leave on the m_t* channel; m_tuser is 0 for a hardware
// register write and 1 for read data, and m_tlast marks the final result of
// a request. Configuration registers are written on the cfg_* channel, which
// is always ready and must only be used while the block is idle.
// Sequence: each write, set, clear or read request occupies the block for
// the registered shadow RAM read followed by the modify-and-write or the
// output load, which waits for a free output register. A flush starts with
// a queue RAM read, and each queued register then needs a shadow RAM read
// and an output load, the load also reading the next queue entry. Write,
// set and clear requests with out-of-range indexes, unknown commands and
// empty flushes are taken while idle and produce nothing.
// Reset (rst, synchronous) empties the queue, marks every shadow entry as
// zero through its valid bit, restores the configuration defaults and drops
// any pending result; no clearing pass is needed. When the receiver stalls,
// the result stays in the output register and the next request may still be
// accepted; the block only waits once it has a second result to deliver.
// ---------------------------------------------------------------------------
module shadow_register_deferred_writer
  import srdw_pkg::*;
#(
  parameter int NUM_REGS         = 48,
  parameter int STATUS_INDEX     = 2,
  parameter int LINE_COUNT_INDEX = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cmd[2:0], reg_index[8:3], data[24:9], scanline[32:25], forced_blank[33]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // Result channel.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_index[5:0], out_value[21:6], merge_status[22], read_from_hardware[23]
  output logic [M_TDATA_W-1:0] m_tdata,
  // kind[0]
  output logic                 m_tuser,
  output logic                 m_tlast,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Configuration is taken in the cycle it is offered.
  assign cfg_ready = 1'b1;

  srdw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  srdw_dp #(
    .NUM_REGS         (NUM_REGS),
    .STATUS_INDEX     (STATUS_INDEX),
    .LINE_COUNT_INDEX (LINE_COUNT_INDEX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[design/srdw_checker.sv]
// ---------------------------------------------------------------------------
// srdw_checker
// Port-level checks on the result channel of the shadow register deferred
// writer, attached by a bind statement.
// ---------------------------------------------------------------------------
module srdw_checker
  import srdw_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // A read answers with exactly one result.
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("read result not marked last");

  // Merge applies to writes only, the hardware-read flag to reads only.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser ? !m_tdata[OUT_MERGE_BIT] : !m_tdata[OUT_HW_BIT]))
    else $error("result flags do not match its kind");

  // Reset drops any pending result.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind shadow_register_deferred_writer srdw_checker u_srdw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/sv/shadow_register_deferred_writer_test.sv]
// ---------------------------------------------------------------------------
// shadow_register_deferred_writer_test
// Self-checking bench for the shadow register deferred writer. A clocked
// driver feeds requests from a queue, a clocked monitor compares every
// result with the bench's own mirror of the shadow file and pending queue.
// ---------------------------------------------------------------------------
module shadow_register_deferred_writer_test;
  import srdw_pkg::*;

  localparam int REG_COUNT      = 48;
  localparam int STATUS_REG     = 2;
  localparam int LINE_COUNT_REG = 3;

  // Command codes the block must ignore.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  // Result kinds as carried on m_tuser.
  localparam logic KIND_HW_WRITE  = 1'b0;
  localparam logic KIND_READ_DATA = 1'b1;

  localparam logic [VAL_W-1:0] MERGE_MASK_RST = 16'h0018;

  localparam int IDLE_PCT    = 29;   // chance in a hundred of an idle cycle
  localparam int SETTLE      = 8;    // hold-off before a configuration write
  localparam int END_CYCLES  = 16;   // quiet time at the very end
  localparam int QUIET_LIMIT = 2000; // cycles without any handshake

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  data;
    logic [LINE_W-1:0] scanline;
    logic              fblank;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             merge;
    logic             from_hw;
    logic             last;
  } bus_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  shadow_register_deferred_writer #(
    .NUM_REGS        (REG_COUNT),
    .STATUS_INDEX    (STATUS_REG),
    .LINE_COUNT_INDEX(LINE_COUNT_REG)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block: shadow file, pending write list and configuration.
  // The shadow array is sized for every six-bit index so that an
  // out-of-range request can never index past its end.
  logic [VAL_W-1:0]  shadow_copy [64] = '{default: '0};
  logic [IDX_W-1:0]  flush_order [$];
  logic [63:0]       queued_marks = '0;
  logic [LINE_W-1:0] win_first = BLANK_FIRST_RST;
  logic [LINE_W-1:0] win_last  = BLANK_LAST_RST;
  logic [VAL_W-1:0]  merge_mask = MERGE_MASK_RST;

  req_t        requests_waiting [$];
  bus_result_t results_due [$];
  req_t        on_bus;
  int          requests_queued = 0;
  int          requests_taken  = 0;
  int          mismatch_count  = 0;
  int          quiet_cycles    = 0;
  bit          steady_flow     = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Works out what one accepted request does to the mirror and which
  // results it must cause, in the order the block has to deliver them.
  task automatic apply_to_shadow(input req_t r);
    bus_result_t res;
    logic [VAL_W-1:0] v;
    bit in_range;
    bit in_window;
    in_range = r.index < REG_COUNT;
    case (r.cmd) inside
      CMD_WRITE, CMD_SET, CMD_CLEAR: begin
        // Out-of-range modifies are dropped without trace.
        if (in_range) begin
          v = shadow_copy[r.index];
          if (r.cmd == CMD_WRITE) v = r.data;
          else if (r.cmd == CMD_SET) v = v | r.data;
          else v = v & ~r.data;
          shadow_copy[r.index] = v;
          // An empty window (first above last) never matches here.
          in_window = (r.scanline >= win_first) && (r.scanline <= win_last);
          if (in_window || r.fblank) begin
            res = '{KIND_HW_WRITE, r.index, v, r.index == STATUS_REG, 1'b0, 1'b1};
            results_due.push_back(res);
          end else if (!queued_marks[r.index]) begin
            // A register already waiting keeps its place in the list.
            flush_order.push_back(r.index);
            queued_marks[r.index] = 1'b1;
          end
        end
      end
      CMD_READ: begin
        res = '{KIND_READ_DATA, r.index, in_range ? shadow_copy[r.index] : '0, 1'b0,
                (r.index == STATUS_REG) || (r.index == LINE_COUNT_REG), 1'b1};
        results_due.push_back(res);
      end
      CMD_FLUSH: begin
        // Each entry carries the shadow value as it stands now, not as it
        // stood when the register was queued. An empty list gives nothing.
        foreach (flush_order[i]) begin
          res = '{KIND_HW_WRITE, flush_order[i], shadow_copy[flush_order[i]],
                  flush_order[i] == STATUS_REG, 1'b0, i == flush_order.size() - 1};
          results_due.push_back(res);
        end
        flush_order.delete();
        queued_marks = '0;
      end
      default: ;
    endcase
  endtask

  // Driver: presents the next waiting request, holds it until the block
  // takes it and sometimes leaves a gap before the next one.
  always @(posedge clk) begin : drive_requests
    logic [S_TDATA_W-1:0] word;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_to_shadow(on_bus);
        requests_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (requests_waiting.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = requests_waiting.pop_front();
          word = '0;
          word[IN_CMD_LSB  +: CMD_W]  = on_bus.cmd;
          word[IN_IDX_LSB  +: IDX_W]  = on_bus.index;
          word[IN_DATA_LSB +: VAL_W]  = on_bus.data;
          word[IN_LINE_LSB +: LINE_W] = on_bus.scanline;
          word[IN_FBLK_BIT]           = on_bus.fblank;
          s_tvalid <= 1'b1;
          s_tdata  <= word;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: every result taken from the block is checked against the
  // oldest outstanding one. It also keeps the count of handshake-free
  // cycles that the watchdog looks at.
  always @(posedge clk) begin : watch_results
    bus_result_t got;
    bus_result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (m_tvalid && m_tready) begin
        got.kind    = m_tuser;
        got.index   = m_tdata[OUT_IDX_LSB +: IDX_W];
        got.value   = m_tdata[OUT_VAL_LSB +: VAL_W];
        got.merge   = m_tdata[OUT_MERGE_BIT];
        got.from_hw = m_tdata[OUT_HW_BIT];
        got.last    = m_tlast;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %b index %0d value %h",
                                    got.kind, got.index, got.value));
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.index !== want.index ||
              got.value !== want.value || got.merge !== want.merge ||
              got.from_hw !== want.from_hw || got.last !== want.last) begin
            report_mismatch($sformatf(
              "got kind %b idx %0d val %h merge %b hw %b last %b, want %b %0d %h %b %b %b",
              got.kind, got.index, got.value, got.merge, got.from_hw, got.last,
              want.kind, want.index, want.value, want.merge, want.from_hw, want.last));
          end
        end
      end
    end
  end

  // Watchdog: gives up once the bench has gone too long without any
  // handshake on any channel.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[shadow_register_deferred_writer] ERROR");
    $finish;
  end

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] index,
                               input logic [VAL_W-1:0] data,
                               input logic [LINE_W-1:0] scanline, input logic fblank);
    requests_waiting.push_back('{cmd, index, data, scanline, fblank});
    requests_queued++;
  endtask

  // Scanlines cluster around the edges of the current window, where the
  // decision between a direct write and a queued one flips.
  function automatic logic [LINE_W-1:0] pick_scanline();
    case ($urandom_range(0, 7))
      0: return win_first;
      1: return win_first - 8'd1;
      2: return win_last;
      3: return win_last + 8'd1;
      default: return LINE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly modifies of valid registers (some confined to a few indexes so
  // that duplicates in the pending list are common), with reads and
  // flushes mixed in, plus out-of-range and unknown requests as noise.
  function automatic req_t draw_request();
    req_t r;
    int roll;
    roll       = $urandom_range(0, 99);
    r.data     = VAL_W'($urandom_range(0, 16'hFFFF));
    r.scanline = pick_scanline();
    r.fblank   = $urandom_range(0, 99) < 15;
    r.index    = IDX_W'($urandom_range(0, REG_COUNT - 1));
    r.cmd      = CMD_W'($urandom_range(CMD_WRITE, CMD_CLEAR));
    if (roll < 45) begin
      // plain modify of any valid register
    end else if (roll < 60) begin
      r.index = IDX_W'($urandom_range(0, 7));
    end else if (roll < 72) begin
      r.cmd   = CMD_READ;
      r.index = IDX_W'($urandom_range(0, 63));
    end else if (roll < 84) begin
      r.cmd = CMD_FLUSH;
    end else if (roll < 93) begin
      r.index = IDX_W'($urandom_range(REG_COUNT, 63));
    end else begin
      r.cmd   = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      r.index = IDX_W'($urandom_range(0, 63));
    end
    return r;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) begin
      requests_waiting.push_back(draw_request());
      requests_queued++;
    end
  endtask

  // Returns once every queued request has been taken and every result has
  // arrived, then lets the block finish any request that causes nothing.
  task automatic wait_until_quiet(input int extra);
    while (requests_taken != requests_queued || results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] which, input logic [VAL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      CFG_BLANK_FIRST: win_first  = value[LINE_W-1:0];
      CFG_BLANK_LAST:  win_last   = value[LINE_W-1:0];
      CFG_MERGE_MASK:  merge_mask = value;
      default: ;
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset window [161, 225].
    queue_request(CMD_READ,  6'd0,  16'h0000, 8'd0,   1'b0); // untouched shadow
    queue_request(CMD_READ,  6'd2,  16'h0000, 8'd0,   1'b0); // status from hardware
    queue_request(CMD_READ,  6'd3,  16'h0000, 8'd0,   1'b0); // line count from hardware
    queue_request(CMD_READ,  6'd63, 16'hFFFF, 8'd255, 1'b1); // out of range reads zero
    queue_request(CMD_WRITE, 6'd0,  16'hFFFF, 8'd161, 1'b0); // first line of window
    queue_request(CMD_WRITE, 6'd2,  16'hA5A5, 8'd225, 1'b0); // last line, status merge
    queue_request(CMD_WRITE, 6'd5,  16'h1234, 8'd160, 1'b0); // just before window
    queue_request(CMD_WRITE, 6'd5,  16'h5678, 8'd226, 1'b0); // already queued
    queue_request(CMD_SET,   6'd7,  16'h00F0, 8'd255, 1'b0);
    queue_request(CMD_CLEAR, 6'd47, 16'hFFFF, 8'd0,   1'b0);
    queue_request(CMD_SET,   6'd2,  16'h0F00, 8'd0,   1'b0); // status queued
    queue_request(CMD_WRITE, 6'd48, 16'hFFFF, 8'd0,   1'b0); // out of range, dropped
    queue_request(CMD_SET,   6'd63, 16'hFFFF, 8'd200, 1'b1); // out of range, dropped
    queue_request(CMD_RSVD_FIRST, 6'd1, 16'hFFFF, 8'd255, 1'b1);
    queue_request(CMD_RSVD_MID,   6'd2, 16'h0000, 8'd170, 1'b0);
    queue_request(CMD_RSVD_LAST,  6'd63, 16'h8001, 8'd0,  1'b1);
    queue_request(CMD_FLUSH, 6'd0,  16'h0000, 8'd0,   1'b0); // four entries
    queue_request(CMD_FLUSH, 6'd63, 16'hFFFF, 8'd255, 1'b1); // nothing pending
    queue_request(CMD_CLEAR, 6'd0,  16'h00FF, 8'd0,   1'b1); // forced blank
    queue_request(CMD_SET,   6'd3,  16'h8000, 8'd100, 1'b1);
    queue_request(CMD_READ,  6'd0,  16'h0000, 8'd0,   1'b0);
    queue_request(CMD_READ,  6'd2,  16'h0000, 8'd0,   1'b0);
    queue_request(CMD_WRITE, 6'd1,  16'h0000, 8'd10,  1'b0);
    queue_request(CMD_FLUSH, 6'd0,  16'h0000, 8'd0,   1'b0); // single entry
    wait_until_quiet(SETTLE);

    // Window spans every scanline: every modify goes straight out.
    write_setting(CFG_BLANK_FIRST, 16'd0);
    write_setting(CFG_BLANK_LAST,  16'd255);
    write_setting(CFG_MERGE_MASK,  16'hFFFF);
    queue_random(60);
    wait_until_quiet(SETTLE);

    // Empty window: only forced blank bypasses the list. Queue every
    // register once so that one flush delivers the whole file.
    write_setting(CFG_BLANK_FIRST, 16'd200);
    write_setting(CFG_BLANK_LAST,  16'd100);
    write_setting(CFG_MERGE_MASK,  16'h0000);
    for (int i = 0; i < REG_COUNT; i++) begin
      queue_request(CMD_W'($urandom_range(CMD_WRITE, CMD_CLEAR)), IDX_W'(i),
                    VAL_W'($urandom_range(0, 16'hFFFF)),
                    LINE_W'($urandom_range(0, 255)), 1'b0);
    end
    queue_request(CMD_FLUSH, 6'd0, 16'h0000, 8'd0, 1'b0);
    queue_random(60);
    wait_until_quiet(SETTLE);

    // One-line window, with both sides running flat out.
    write_setting(CFG_BLANK_FIRST, 16'd0);
    write_setting(CFG_BLANK_LAST,  16'd0);
    write_setting(CFG_MERGE_MASK,  MERGE_MASK_RST);
    steady_flow = 1'b1;
    queue_random(50);
    wait_until_quiet(SETTLE);
    steady_flow = 1'b0;

    // Random window, which may come out empty.
    write_setting(CFG_BLANK_FIRST, VAL_W'($urandom_range(0, 255)));
    write_setting(CFG_BLANK_LAST,  VAL_W'($urandom_range(0, 255)));
    write_setting(CFG_MERGE_MASK,  VAL_W'($urandom_range(0, 16'hFFFF)));
    queue_random(60);
    queue_request(CMD_FLUSH, 6'd0, 16'h0000, 8'd0, 1'b0);
    wait_until_quiet(END_CYCLES);

    if (mismatch_count == 0) begin
      $display("[shadow_register_deferred_writer] OK");
    end else begin
      $display("[shadow_register_deferred_writer] ERROR");
    end
    $finish;
  end

endmodule
